### sv/csbt_pkg.sv
// shared types, token codes and keyword tables for the byte tokenizer
// no dependencies; imported by every tokenizer module
`timescale 1ns / 1ps
`default_nettype none

package csbt_pkg;

    localparam logic [3:0] KIND_END     = 4'd0;
    localparam logic [3:0] KIND_INT     = 4'd1;
    localparam logic [3:0] KIND_IDENT   = 4'd6;
    localparam logic [3:0] KIND_NUMBER  = 4'd7;
    localparam logic [3:0] KIND_STRCHAR = 4'd8;
    localparam logic [3:0] KIND_STREND  = 4'd9;
    localparam logic [3:0] KIND_LPAREN  = 4'd10;
    localparam logic [3:0] KIND_RPAREN  = 4'd11;
    localparam logic [3:0] KIND_LBRACE  = 4'd12;
    localparam logic [3:0] KIND_RBRACE  = 4'd13;
    localparam logic [3:0] KIND_SEMI    = 4'd14;
    localparam logic [3:0] KIND_STRAY   = 4'd15;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_N      = 8'h6E;

    localparam int KW_COUNT = 5;

    typedef enum logic [5:0] {
        MODE_IDLE = 6'b000001,
        MODE_LINE = 6'b000010,
        MODE_WORD = 6'b000100,
        MODE_NUM  = 6'b001000,
        MODE_STR  = 6'b010000,
        MODE_ESC  = 6'b100000
    } mode_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] sbyte;
    } slot_t;

    // all results caused by one source byte
    typedef struct packed {
        logic [1:0]      cnt;
        slot_t [2:0]     slot;
        logic [31:0]     num;
    } bundle_t;

    function automatic logic [2:0] kw_len(input logic [2:0] idx);
        logic [2:0] r;
        case (idx)
            3'd0:    r = 3'd3;
            3'd1:    r = 3'd4;
            3'd2:    r = 3'd4;
            3'd3:    r = 3'd6;
            3'd4:    r = 3'd6;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // keyword text, first character in the top byte
    function automatic logic [5:0][7:0] kw_text(input logic [2:0] idx);
        logic [5:0][7:0] r;
        case (idx)
            3'd0:    r = {"int", 24'h0};
            3'd1:    r = {"void", 16'h0};
            3'd2:    r = {"main", 16'h0};
            3'd3:    r = "printf";
            3'd4:    r = "return";
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_char(input logic [2:0] idx, input logic [2:0] pos);
        logic [5:0][7:0] t;
        logic [7:0]      r;
        t = kw_text(idx);
        r = 8'h00;
        if (pos < 3'd6)
            r = t[3'd5 - pos];
        return r;
    endfunction

    // drop candidates that the new character rules out
    function automatic logic [4:0] kw_feed(input logic [4:0] cand, input logic [2:0] pos,
                                           input logic [7:0] b);
        logic [4:0] r;
        r = cand;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (!(pos < kw_len(3'(i)) && kw_char(3'(i), pos) == b))
                r[i] = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [3:0] kw_kind(input logic [4:0] cand, input logic [2:0] pos);
        logic [3:0] r;
        r = KIND_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            if (cand[i] && kw_len(3'(i)) == pos)
                r = 4'(i) + KIND_INT;
        end
        return r;
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

endpackage

`default_nettype wire

### sv/csbt_front.sv
// front end: takes one source byte per beat, tracks scan state, forms result bundles
// depends on csbt_pkg
`timescale 1ns / 1ps
`default_nettype none

module csbt_front
    import csbt_pkg::*;
#(
    parameter int NUMBER_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic [7:0]  source_byte,
    input  wire logic        q_full,
    output logic             full,
    output logic             q_push,
    output bundle_t          q_data
);

    localparam int NW = NUMBER_WIDTH;

    mode_t            mode_reg, mode_next;
    logic [NW-1:0]    acc_reg, acc_next;
    logic [4:0]       cand_reg, cand_next;
    logic [2:0]       pos_reg, pos_next;

    logic             accept;
    logic [7:0]       b;
    logic [NW+31:0]   acc_ext;
    logic [NW-1:0]    digit;
    logic [2:0]       pos_inc;

    // outcome of handling the byte between tokens
    logic             idle_emit;
    logic [3:0]       idle_kind;
    mode_t            idle_mode;

    bundle_t          bnd;
    logic [1:0]       n;

    assign full    = q_full;
    assign accept  = push && !q_full;
    assign b       = source_byte;
    assign acc_ext = {32'b0, acc_reg};
    assign digit   = NW'(b - CH_ZERO);
    assign pos_inc = (pos_reg == 3'd7) ? 3'd7 : pos_reg + 3'd1;

    always_comb
    begin
        idle_emit = 1'b0;
        idle_kind = KIND_STRAY;
        idle_mode = MODE_IDLE;
        if (b == CH_NUL)
        begin
            idle_emit = 1'b1;
            idle_kind = KIND_END;
        end
        else if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF)
        begin
            idle_emit = 1'b0;
        end
        else if (b == CH_HASH)
            idle_mode = MODE_LINE;
        else if (is_alpha(b))
            idle_mode = MODE_WORD;
        else if (is_digit(b))
            idle_mode = MODE_NUM;
        else if (b == CH_QUOTE)
            idle_mode = MODE_STR;
        else
        begin
            idle_emit = 1'b1;
            case (b)
                "(":     idle_kind = KIND_LPAREN;
                ")":     idle_kind = KIND_RPAREN;
                "{":     idle_kind = KIND_LBRACE;
                "}":     idle_kind = KIND_RBRACE;
                ";":     idle_kind = KIND_SEMI;
                default: idle_kind = KIND_STRAY;
            endcase
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        cand_next = cand_reg;
        pos_next  = pos_reg;
        bnd       = '0;
        n         = 2'd0;

        case (mode_reg)
            MODE_LINE:
            begin
                if (b == CH_NUL)
                begin
                    bnd.slot[n].kind = KIND_END;
                    n = n + 2'd1;
                    mode_next = MODE_IDLE;
                end
                else if (b == CH_LF)
                    mode_next = MODE_IDLE;
            end
            MODE_WORD:
            begin
                if (is_alpha(b) || is_digit(b))
                begin
                    cand_next = kw_feed(cand_reg, pos_reg, b);
                    pos_next  = pos_inc;
                end
                else
                begin
                    bnd.slot[n].kind = kw_kind(cand_reg, pos_reg);
                    n = n + 2'd1;
                end
            end
            MODE_NUM:
            begin
                if (is_digit(b))
                    acc_next = (acc_reg << 3) + (acc_reg << 1) + digit;
                else
                begin
                    bnd.slot[n].kind = KIND_NUMBER;
                    bnd.num = acc_ext[31:0];
                    n = n + 2'd1;
                end
            end
            MODE_ESC:
            begin
                bnd.slot[n].kind = KIND_STRCHAR;
                if (b == CH_N)
                begin
                    bnd.slot[n].sbyte = CH_LF;
                    mode_next = MODE_STR;
                end
                else
                    bnd.slot[n].sbyte = CH_BSLASH;
                n = n + 2'd1;
            end
            default: ;
        endcase

        // string byte handling, also after a backslash not followed by n
        if (mode_reg == MODE_STR || (mode_reg == MODE_ESC && b != CH_N))
        begin
            if (b == CH_NUL)
            begin
                bnd.slot[n].kind = KIND_STREND;
                n = n + 2'd1;
                bnd.slot[n].kind = KIND_END;
                n = n + 2'd1;
                mode_next = MODE_IDLE;
            end
            else if (b == CH_QUOTE)
            begin
                bnd.slot[n].kind = KIND_STREND;
                n = n + 2'd1;
                mode_next = MODE_IDLE;
            end
            else if (b == CH_BSLASH)
                mode_next = MODE_ESC;
            else
            begin
                bnd.slot[n].kind  = KIND_STRCHAR;
                bnd.slot[n].sbyte = b;
                n = n + 2'd1;
                mode_next = MODE_STR;
            end
        end

        // between tokens, or the byte that cut a word or number
        if (mode_reg == MODE_IDLE
            || (mode_reg == MODE_WORD && !(is_alpha(b) || is_digit(b)))
            || (mode_reg == MODE_NUM && !is_digit(b)))
        begin
            mode_next = idle_mode;
            if (idle_emit)
            begin
                bnd.slot[n].kind = idle_kind;
                n = n + 2'd1;
            end
            if (idle_mode == MODE_WORD)
            begin
                cand_next = kw_feed(5'h1F, 3'd0, b);
                pos_next  = 3'd1;
            end
            if (idle_mode == MODE_NUM)
                acc_next = digit;
        end

        bnd.cnt = n;
    end

    assign q_push = accept && (n != 2'd0);
    assign q_data = bnd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= '0;
            cand_reg <= 5'h1F;
            pos_reg  <= 3'd0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cand_reg <= cand_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

`default_nettype wire

### sv/csbt_queue.sv
// short bundle queue between the front end and the result stage
// depends on csbt_pkg
`timescale 1ns / 1ps
`default_nettype none

module csbt_queue
    import csbt_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     wr,
    input  wire bundle_t  wr_data,
    input  wire logic     rd,
    output logic          full,
    output logic          avail,
    output bundle_t       rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bundle_t          mem_reg [DEPTH];
    logic [PW-1:0]    wp_reg, wp_next;
    logic [PW-1:0]    rp_reg, rp_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = cnt_reg == CW'(DEPTH);
    assign avail   = cnt_reg != '0;
    assign rd_data = mem_reg[rp_reg];
    assign do_wr   = wr && !full;
    assign do_rd   = rd && avail;

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_wr)
            wp_next = (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + PW'(1);
        if (do_rd)
            rp_next = (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + PW'(1);
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + CW'(1);
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_data;
    end

endmodule

`default_nettype wire

### sv/csbt_back.sv
// result stage: splits each bundle into single result beats behind an output register
// depends on csbt_pkg
`timescale 1ns / 1ps
`default_nettype none

module csbt_back
    import csbt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     q_avail,
    input  wire bundle_t  q_data,
    output logic          q_rd,
    input  wire logic     pop,
    output logic          empty,
    output logic [3:0]    token_kind,
    output logic [31:0]   number_value,
    output logic [7:0]    string_byte,
    output logic          last_of_run
);

    logic        bnd_valid_reg, bnd_valid_next;
    bundle_t     bnd_reg;
    logic [1:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    logic [3:0]  kind_reg;
    logic [31:0] num_reg;
    logic [7:0]  sbyte_reg;
    logic        last_reg;

    logic        out_load;
    logic        bnd_done;
    logic        bnd_load;
    slot_t       cur;

    assign cur      = bnd_reg.slot[idx_reg];
    assign out_load = bnd_valid_reg && (!out_valid_reg || pop);
    assign bnd_done = out_load && (idx_reg == bnd_reg.cnt - 2'd1);
    assign bnd_load = q_avail && (!bnd_valid_reg || bnd_done);
    assign q_rd     = bnd_load;

    always_comb
    begin
        bnd_valid_next = bnd_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (bnd_load)
        begin
            bnd_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
        else if (bnd_done)
            bnd_valid_next = 1'b0;
        else if (out_load)
            idx_next = idx_reg + 2'd1;
        if (out_load)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bnd_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bnd_valid_reg <= bnd_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bnd_load)
            bnd_reg <= q_data;
        if (out_load)
        begin
            kind_reg  <= cur.kind;
            num_reg   <= (cur.kind == KIND_NUMBER) ? bnd_reg.num : 32'd0;
            sbyte_reg <= cur.sbyte;
            last_reg  <= bnd_done;
        end
    end

    assign empty        = !out_valid_reg;
    assign token_kind   = kind_reg;
    assign number_value = num_reg;
    assign string_byte  = sbyte_reg;
    assign last_of_run  = last_reg;

endmodule

`default_nettype wire

### sv/c_subset_byte_tokenizer_unit.sv
// byte tokenizer top: one source byte accepted per cycle while the bundle queue has room
// first result of a byte passes the bundle queue, the bundle register and the output register before it shows
// results leave at one per cycle while pop is held; a byte giving up to 3 results is split by the result stage
// reset (rst_n low, asynchronous) empties the queue and output and returns to between tokens
// depends on csbt_pkg, csbt_front, csbt_queue, csbt_back
`timescale 1ns / 1ps
`default_nettype none

module c_subset_byte_tokenizer_unit
    import csbt_pkg::*;
#(
    parameter int NUMBER_WIDTH = 32,
    parameter int QUEUE_DEPTH  = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  source_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [3:0]       token_kind,
    output logic [31:0]      number_value,
    output logic [7:0]       string_byte,
    output logic             last_of_run
);

    logic     q_full;
    logic     q_push;
    bundle_t  q_wr_data;
    logic     q_rd;
    logic     q_avail;
    bundle_t  q_rd_data;

    csbt_front #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .source_byte (source_byte),
        .q_full      (q_full),
        .full        (full),
        .q_push      (q_push),
        .q_data      (q_wr_data)
    );

    csbt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .wr_data (q_wr_data),
        .rd      (q_rd),
        .full    (q_full),
        .avail   (q_avail),
        .rd_data (q_rd_data)
    );

    csbt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_avail      (q_avail),
        .q_data       (q_rd_data),
        .q_rd         (q_rd),
        .pop          (pop),
        .empty        (empty),
        .token_kind   (token_kind),
        .number_value (number_value),
        .string_byte  (string_byte),
        .last_of_run  (last_of_run)
    );

endmodule

`default_nettype wire

### tb/sv/csbt_checker.sv
`timescale 1ns / 1ps
// token checker for the byte tokenizer: predicts the tokens of every accepted
// source beat and compares them with the result beats; depends on csbt_pkg

module csbt_checker
    import csbt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic        full,
    input  wire logic [7:0]  source_byte,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic [3:0]  token_kind,
    input  wire logic [31:0] number_value,
    input  wire logic [7:0]  string_byte,
    input  wire logic        last_of_run,
    output int               mismatches,
    output int               pending
);

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] num;
        logic [7:0]  sbyte;
        logic        last;
    } token_t;

    token_t      expected_tokens [$];
    token_t      run_tokens [0:2];
    int          run_len = 0;
    int          error_count = 0;

    // scanner state, mirrors the block from reset on
    mode_t       scan_state = MODE_IDLE;
    logic [31:0] acc = '0;
    logic [4:0]  candidates = 5'h1F;
    logic [2:0]  word_len = '0;

    function automatic logic is_word_start(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic logic is_decimal(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    // keyword spelling, left aligned and padded with zero bytes
    function automatic logic [47:0] keyword_spelling(input int k);
        logic [47:0] text;
        case (k)
            0:       text = {"int", 24'h0};
            1:       text = {"void", 16'h0};
            2:       text = {"main", 16'h0};
            3:       text = "printf";
            default: text = "return";
        endcase
        return text;
    endfunction

    function automatic int keyword_length(input int k);
        logic [47:0] text;
        int          n;
        text = keyword_spelling(k);
        n = 0;
        for (int p = 0; p < 6; p++)
            if (text[8*(5-p) +: 8] != 8'h00)
                n++;
        return n;
    endfunction

    task automatic add_token(input logic [3:0] kind, input logic [31:0] num,
                             input logic [7:0] sbyte);
        run_tokens[run_len] = {kind, num, sbyte, 1'b0};
        run_len++;
    endtask

    task automatic advance_word(input logic [7:0] b);
        logic [47:0] text;
        for (int k = 0; k < 5; k++) begin
            text = keyword_spelling(k);
            if (!(int'(word_len) < keyword_length(k) && text[8*(5-word_len) +: 8] == b))
                candidates[k] = 1'b0;
        end
        if (word_len != 3'd7)
            word_len = word_len + 3'd1;
    endtask

    function automatic logic [3:0] finished_word_kind();
        logic [3:0] kind;
        kind = KIND_IDENT;
        for (int k = 4; k >= 0; k--)
            if (candidates[k] && keyword_length(k) == int'(word_len))
                kind = KIND_INT + 4'(k);
        return kind;
    endfunction

    task automatic between_tokens(input logic [7:0] b);
        scan_state = MODE_IDLE;
        case (b)
            CH_NUL:                         add_token(KIND_END, '0, '0);
            CH_SPACE, CH_TAB, CH_CR, CH_LF:
            begin
                // whitespace is dropped
            end
            CH_HASH:                        scan_state = MODE_LINE;
            CH_QUOTE:                       scan_state = MODE_STR;
            "(":                            add_token(KIND_LPAREN, '0, '0);
            ")":                            add_token(KIND_RPAREN, '0, '0);
            "{":                            add_token(KIND_LBRACE, '0, '0);
            "}":                            add_token(KIND_RBRACE, '0, '0);
            ";":                            add_token(KIND_SEMI, '0, '0);
            default:
            begin
                if (is_word_start(b))
                begin
                    scan_state = MODE_WORD;
                    candidates = 5'h1F;
                    word_len = '0;
                    advance_word(b);
                end
                else if (is_decimal(b))
                begin
                    scan_state = MODE_NUM;
                    acc = {24'd0, b - CH_ZERO};
                end
                else
                begin
                    add_token(KIND_STRAY, '0, '0);
                end
            end
        endcase
    endtask

    task automatic inside_string(input logic [7:0] b);
        if (b == CH_NUL)
        begin
            add_token(KIND_STREND, '0, '0);
            add_token(KIND_END, '0, '0);
            scan_state = MODE_IDLE;
        end
        else if (b == CH_QUOTE)
        begin
            add_token(KIND_STREND, '0, '0);
            scan_state = MODE_IDLE;
        end
        else if (b == CH_BSLASH)
        begin
            scan_state = MODE_ESC;
        end
        else
        begin
            add_token(KIND_STRCHAR, '0, b);
            scan_state = MODE_STR;
        end
    endtask

    task automatic predict_byte(input logic [7:0] b);
        run_len = 0;
        case (scan_state)
            MODE_LINE:
            begin
                if (b == CH_NUL)
                    between_tokens(b);
                else if (b == CH_LF)
                    scan_state = MODE_IDLE;
            end
            MODE_WORD:
            begin
                if (is_word_start(b) || is_decimal(b))
                begin
                    advance_word(b);
                end
                else
                begin
                    // pending word goes out first, then the cutting byte
                    add_token(finished_word_kind(), '0, '0);
                    between_tokens(b);
                end
            end
            MODE_NUM:
            begin
                if (is_decimal(b))
                begin
                    acc = acc * 32'd10 + {24'd0, b - CH_ZERO};
                end
                else
                begin
                    add_token(KIND_NUMBER, acc, '0);
                    between_tokens(b);
                end
            end
            MODE_STR:
            begin
                inside_string(b);
            end
            MODE_ESC:
            begin
                if (b == CH_N)
                begin
                    add_token(KIND_STRCHAR, '0, CH_LF);
                    scan_state = MODE_STR;
                end
                else
                begin
                    // lone backslash is kept, the byte is then handled as any byte inside a string
                    add_token(KIND_STRCHAR, '0, CH_BSLASH);
                    inside_string(b);
                end
            end
            default:
            begin
                between_tokens(b);
            end
        endcase
        if (run_len > 0)
            run_tokens[run_len-1].last = 1'b1;
        for (int i = 0; i < run_len; i++)
            expected_tokens.push_back(run_tokens[i]);
    endtask

    always @(posedge clk)
    begin : watch
        token_t want;
        token_t got;
        logic   bad;
        if (rst_n)
        begin
            // result side first so a beat never meets its own prediction
            if (pop && !empty)
            begin
                got = {token_kind, number_value, string_byte, last_of_run};
                if (expected_tokens.size() == 0)
                begin
                    $display("%0t: result beat with none expected, got kind %0d", $time,
                             token_kind);
                    error_count++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    bad = 1'b0;
                    if (got.kind !== want.kind)
                    begin
                        $display("%0t: token_kind expected %0d, got %0d", $time,
                                 want.kind, got.kind);
                        bad = 1'b1;
                    end
                    if (got.num !== want.num)
                    begin
                        $display("%0t: number_value expected %0d, got %0d", $time,
                                 want.num, got.num);
                        bad = 1'b1;
                    end
                    if (got.sbyte !== want.sbyte)
                    begin
                        $display("%0t: string_byte expected 0x%02h, got 0x%02h", $time,
                                 want.sbyte, got.sbyte);
                        bad = 1'b1;
                    end
                    if (got.last !== want.last)
                    begin
                        $display("%0t: last_of_run expected %0b, got %0b", $time,
                                 want.last, got.last);
                        bad = 1'b1;
                    end
                    if (bad)
                        error_count++;
                end
            end
            if (push && !full)
                predict_byte(source_byte);
            mismatches <= error_count;
            pending <= expected_tokens.size();
        end
    end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// testbench top for c_subset_byte_tokenizer_unit: feeds directed and random
// source text, drains tokens with random stalls; depends on csbt_pkg, csbt_checker

module tb_top;
    import csbt_pkg::*;

    localparam int ITEM_TARGET  = 480;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int DIRECTED_LEN = 23;

    // keyword, punctuation, both escape kinds, end in a string, high bytes,
    // end in a '#' line, end right after a backslash
    localparam logic [8*DIRECTED_LEN-1:0] DIRECTED_SOURCE = {
        "int(){9};",
        CH_QUOTE, CH_BSLASH, CH_N, CH_BSLASH, "z", CH_NUL,
        8'hFF, 8'h80,
        CH_HASH, "x", CH_NUL,
        CH_QUOTE, CH_BSLASH, CH_NUL
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  source_byte = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [3:0]  token_kind;
    logic [31:0] number_value;
    logic [7:0]  string_byte;
    logic        last_of_run;
    int          mismatches;
    int          pending;

    logic [7:0]  source_q [$];
    int          sent = 0;
    logic        feed_idle_on = 1'b1;
    logic        drain_idle_on = 1'b1;
    int          quiet_cycles = 0;

    always #2 clk = ~clk;

    c_subset_byte_tokenizer_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .source_byte  (source_byte),
        .empty        (empty),
        .pop          (pop),
        .token_kind   (token_kind),
        .number_value (number_value),
        .string_byte  (string_byte),
        .last_of_run  (last_of_run)
    );

    csbt_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .source_byte  (source_byte),
        .empty        (empty),
        .pop          (pop),
        .token_kind   (token_kind),
        .number_value (number_value),
        .string_byte  (string_byte),
        .last_of_run  (last_of_run),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    function automatic logic [7:0] random_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return 8'("a" + r);
        else if (r < 52)
            return 8'("A" + r - 26);
        return "_";
    endfunction

    function automatic logic [7:0] random_digit();
        return 8'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] random_word_char();
        return ($urandom_range(0, 3) == 0) ? random_digit() : random_letter();
    endfunction

    function automatic logic [7:0] random_blank();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [47:0] keyword_spelling(input int k);
        case (k)
            0:       return {"int", 24'h0};
            1:       return {"void", 16'h0};
            2:       return {"main", 16'h0};
            3:       return "printf";
            default: return "return";
        endcase
    endfunction

    // one token-sized piece of source text, mostly well formed
    task automatic add_fragment();
        int          pick;
        int          k;
        int          n;
        int          len;
        logic [47:0] text;
        logic [7:0]  c;
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            k = $urandom_range(0, 4);
            text = keyword_spelling(k);
            len = (k == 0) ? 3 : (k < 3) ? 4 : 6;
            case ($urandom_range(0, 2))
                0:       n = len;
                1:       n = $urandom_range(1, len);
                default: n = len;
            endcase
            for (int i = 0; i < n; i++)
                source_q.push_back(text[8*(5-i) +: 8]);
            // keyword with a tail is a plain identifier
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) source_q.push_back(random_word_char());
        end
        else if (pick < 35)
        begin
            source_q.push_back(random_letter());
            repeat ($urandom_range(0, 8)) source_q.push_back(random_word_char());
        end
        else if (pick < 50)
        begin
            // long runs wrap the 32-bit value
            repeat ($urandom_range(1, 14)) source_q.push_back(random_digit());
        end
        else if (pick < 62)
        begin
            source_q.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 6))
            begin
                k = $urandom_range(0, 99);
                if (k < 70)
                begin
                    c = 8'($urandom_range(32, 126));
                    if (c == CH_QUOTE || c == CH_BSLASH)
                        c = "q";
                    source_q.push_back(c);
                end
                else if (k < 85)
                begin
                    source_q.push_back(CH_BSLASH);
                    source_q.push_back(CH_N);
                end
                else if (k < 95)
                begin
                    source_q.push_back(CH_BSLASH);
                    source_q.push_back(8'($urandom_range(1, 255)));
                end
                else
                begin
                    source_q.push_back(8'($urandom_range(128, 255)));
                end
            end
            if ($urandom_range(0, 9) != 0)
                source_q.push_back(CH_QUOTE);
        end
        else if (pick < 74)
        begin
            case ($urandom_range(0, 4))
                0:       source_q.push_back("(");
                1:       source_q.push_back(")");
                2:       source_q.push_back("{");
                3:       source_q.push_back("}");
                default: source_q.push_back(";");
            endcase
        end
        else if (pick < 82)
        begin
            source_q.push_back(CH_HASH);
            repeat ($urandom_range(0, 8)) source_q.push_back(8'($urandom_range(1, 255)));
            source_q.push_back(CH_LF);
        end
        else if (pick < 94)
        begin
            source_q.push_back(8'($urandom_range(1, 255)));
        end
        else
        begin
            source_q.push_back(CH_NUL);
        end
        if ($urandom_range(0, 1) == 0)
            source_q.push_back(random_blank());
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = feed_idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        source_byte <= b;
        do @(posedge clk); while (full);
        sent++;
    endtask

    // hold the sender until every predicted token has been drained
    task automatic wait_for_drain();
        push <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial
    begin : drain
        int stall;
        int beats;
        beats = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        pop <= 1'b1;
        forever
        begin
            do @(posedge clk); while (empty);
            beats++;
            if (beats % 40 == 0)
                drain_idle_on = ($urandom_range(0, 2) != 0);
            stall = drain_idle_on ? $urandom_range(0, 15) : 0;
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
                pop <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < DIRECTED_LEN; i++)
            send_byte(DIRECTED_SOURCE[8*(DIRECTED_LEN-1-i) +: 8]);
        wait_for_drain();
        while (sent < ITEM_TARGET)
        begin
            if (source_q.size() == 0)
                add_fragment();
            send_byte(source_q.pop_front());
            // alternate stretches with and without sender gaps
            if (sent % 60 == 0)
                feed_idle_on = ($urandom_range(0, 2) != 0);
            if (sent == ITEM_TARGET / 2)
                wait_for_drain();
        end
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### c_subset_byte_tokenizer_unit.f
sv/csbt_pkg.sv
sv/csbt_front.sv
sv/csbt_queue.sv
sv/csbt_back.sv
sv/c_subset_byte_tokenizer_unit.sv
tb/sv/csbt_checker.sv
tb/sv/tb_top.sv
